// ===== rtl/r9e5_pkg.sv =====
// shared types, constants and lane functions for the rgb9e5 codec
package r9e5_pkg;

    localparam int unsigned LANES = 3;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned MANT_W = 9;
    localparam int unsigned EXP_W = 5;

    localparam logic [31:0] POS_INF_BITS = 32'h7f80_0000;
    localparam logic [31:0] CLAMP_MAX_BITS = 32'h477f_8000;
    localparam logic [8:0] MANT_MASK = 9'h1ff;
    localparam logic [7:0] EXP_FLOOR = 8'd111;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [MANT_W-1:0] mant_t;
    typedef logic [EXP_W-1:0] shexp_t;

    typedef struct packed {
        logic  mode;
        word_t red;
        word_t green;
        word_t blue;
        word_t packed_word;
    } in_item_t;

    typedef struct packed {
        word_t packed_word;
        word_t red;
        word_t green;
        word_t blue;
    } out_item_t;

    // clamp a channel to [0, 65408]
    function automatic word_t clamp_channel(input word_t u);
        word_t r;
        if (u > POS_INF_BITS)
            r = '0;
        else if (u >= CLAMP_MAX_BITS)
            r = CLAMP_MAX_BITS;
        else
            r = u;
        return r;
    endfunction

    // shared exponent from the largest clamped channel
    function automatic shexp_t shared_exp(input word_t mx);
        word_t  rnd;
        logic [7:0] e;
        logic [7:0] d;
        rnd = mx + (mx & 32'h0000_4000);
        e = rnd[30:23];
        if (e < EXP_FLOOR)
            e = EXP_FLOOR;
        d = e - EXP_FLOOR;
        return d[EXP_W-1:0];
    endfunction

    // scaled, truncated and halved mantissa with round-up
    function automatic mant_t encode_mant(input word_t u, input shexp_t sx);
        logic [7:0]  e;
        logic [23:0] m;
        logic [8:0]  sh;
        logic [23:0] s;
        logic [9:0]  h;
        e = u[30:23];
        m = {1'b1, u[22:0]};
        if (e == 8'd0)
        begin
            e = 8'd1;
            m = {1'b0, u[22:0]};
        end
        sh = 9'd125 + {4'd0, sx} - {1'b0, e};
        if (sh >= 9'd32)
            s = '0;
        else
            s = m >> sh[4:0];
        h = {1'b0, s[9:1]} + {9'd0, s[0]};
        return h[MANT_W-1:0];
    endfunction

    // mantissa times 2^(shexp-24) as binary32
    function automatic word_t decode_mant(input mant_t m, input shexp_t sx);
        logic [3:0]  p;
        logic [7:0]  ex;
        logic [22:0] fr;
        logic [31:0] wide;
        p = '0;
        for (int i = 1; i < MANT_W; i++)
        begin
            if (m[i])
                p = 4'(i);
        end
        ex = {4'd0, p} + {3'd0, sx} + 8'd103;
        wide = {23'd0, m} << (5'd23 - {1'b0, p});
        fr = wide[22:0];
        if (m == '0)
            return '0;
        return {1'b0, ex, fr};
    endfunction

endpackage

// ===== rtl/r9e5_if.sv =====
// valid/ready channel carrying one payload item
interface r9e5_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/r9e5_lane.sv =====
// one channel lane: clamp on encode front, decode of one mantissa
module r9e5_lane (
    input  r9e5_pkg::word_t  chan,
    input  r9e5_pkg::mant_t  mant,
    input  r9e5_pkg::shexp_t shexp,
    output r9e5_pkg::word_t  clamped,
    output r9e5_pkg::word_t  decoded
);
    // clamp and decode
    assign clamped = r9e5_pkg::clamp_channel(chan);
    assign decoded = r9e5_pkg::decode_mant(mant, shexp);
endmodule

// ===== rtl/r9e5_merge.sv =====
// merge stage: maximum, shared exponent and per-lane mantissa scaling
module r9e5_merge (
    input  r9e5_pkg::word_t  red_c,
    input  r9e5_pkg::word_t  green_c,
    input  r9e5_pkg::word_t  blue_c,
    output r9e5_pkg::word_t  packed_word
);
    r9e5_pkg::word_t  mx;
    r9e5_pkg::shexp_t sx;
    r9e5_pkg::mant_t  rm;
    r9e5_pkg::mant_t  gm;
    r9e5_pkg::mant_t  bm;

    // largest channel, shared exponent and per-lane mantissas
    always_comb
    begin
        mx = red_c;
        if (green_c > mx)
            mx = green_c;
        if (blue_c > mx)
            mx = blue_c;
        sx = r9e5_pkg::shared_exp(mx);
        rm = r9e5_pkg::encode_mant(red_c, sx);
        gm = r9e5_pkg::encode_mant(green_c, sx);
        bm = r9e5_pkg::encode_mant(blue_c, sx);
    end

    assign packed_word = {sx, bm, gm, rm};
endmodule

// ===== rtl/rgb9e5_shared_exponent_codec.sv =====
// top level of the rgb9e5 encode/decode codec
// channel  | role   | payload
// in_ch    | sink   | mode, red, green, blue, packed_word
// out_ch   | source | packed_word, red, green, blue
// one item per clock while out_ch is not stalled; two register stages
// stage one holds clamped channels and decoded lanes, stage two the result
// rst_n clears only the valid bits; stalls hold both stages in place
// input ready follows the stage one register being free or moving on
module rgb9e5_shared_exponent_codec (
    input logic clk,
    input logic rst_n,
    r9e5_if.sink   in_ch,
    r9e5_if.source out_ch
);
    r9e5_pkg::word_t clamped [3];
    r9e5_pkg::word_t decoded [3];
    r9e5_pkg::word_t chans [3];
    r9e5_pkg::mant_t mants [3];

    logic            s1_valid_reg;
    logic            s1_mode_reg;
    r9e5_pkg::word_t s1_c_reg [3];
    r9e5_pkg::word_t s1_d_reg [3];
    logic            s2_valid_reg;
    r9e5_pkg::out_item_t s2_data_reg;
    r9e5_pkg::word_t merged;
    logic            s2_ready;
    logic            s1_ready;

    assign chans[0] = in_ch.data.red;
    assign chans[1] = in_ch.data.green;
    assign chans[2] = in_ch.data.blue;
    assign mants[0] = in_ch.data.packed_word[8:0];
    assign mants[1] = in_ch.data.packed_word[17:9];
    assign mants[2] = in_ch.data.packed_word[26:18];

    // per-channel lanes
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        r9e5_lane u_lane (
            .chan    (chans[i]),
            .mant    (mants[i]),
            .shexp   (in_ch.data.packed_word[31:27]),
            .clamped (clamped[i]),
            .decoded (decoded[i])
        );
    end

    r9e5_merge u_merge (
        .red_c       (s1_c_reg[0]),
        .green_c     (s1_c_reg[1]),
        .blue_c      (s1_c_reg[2]),
        .packed_word (merged)
    );

    assign s2_ready = !s2_valid_reg || out_ch.ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ch.ready = s1_ready;
    assign out_ch.valid = s2_valid_reg;
    assign out_ch.data = s2_data_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_ch.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_ch.valid)
        begin
            s1_mode_reg <= in_ch.data.mode;
            for (int i = 0; i < 3; i++)
            begin
                s1_c_reg[i] <= clamped[i];
                s1_d_reg[i] <= decoded[i];
            end
        end
    end

    // stage two payload
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            if (s1_mode_reg == r9e5_pkg::MODE_DECODE)
            begin
                s2_data_reg.packed_word <= '0;
                s2_data_reg.red   <= s1_d_reg[0];
                s2_data_reg.green <= s1_d_reg[1];
                s2_data_reg.blue  <= s1_d_reg[2];
            end
            else
            begin
                s2_data_reg.packed_word <= merged;
                s2_data_reg.red   <= '0;
                s2_data_reg.green <= '0;
                s2_data_reg.blue  <= '0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_ch.ready |=> s2_valid_reg)
        else $error("result dropped while stalled");
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg)
        else $error("stage one item lost");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_data_reg.packed_word == '0 || s2_data_reg.red == '0))
        else $error("unused fields not zero");
`endif
endmodule
